// File: design/eis_pkg.sv
`timescale 1ns / 1ps
package eis_pkg;

  // Number of cells in the chain, one value per cell
  localparam int CAPACITY = 64;
  // Count width holds 0..CAPACITY
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int DATA_W = 32;

  // Broadcast control to every cell of the chain
  typedef struct packed {
    logic                     ins;
    logic                     shift;
    logic signed [DATA_W-1:0] din;
  } cell_ctrl_t;

endpackage

// File: design/exchange_insertion_sorter.sv
`timescale 1ns / 1ps
// An item is taken into the cell chain at the edge that accepts it; after the item that closes
// a block, the drain state and then the output register lie before the first sorted item, then
// one result per cycle while taken. Input: one item per cycle during fill; a block of held
// values then drains through the cell chain, with input held off during the drain.
// Reset clears the held count, the drop flag, the drain state and the output valid.
module exchange_insertion_sorter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [eis_pkg::DATA_W-1:0] value,
  input  logic                              end_of_block,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [eis_pkg::DATA_W-1:0] sorted_value,
  output logic                              end_of_run,
  output logic                              overflow
);
  import eis_pkg::*;

  typedef enum logic {FILL, DRAIN} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             dropped;
  logic             in_acc;
  logic             insert;
  logic             step;
  cell_ctrl_t       ctrl;

  logic                     cell_gt  [CAPACITY];
  logic signed [DATA_W-1:0] cell_val [CAPACITY];

  assign in_ready = (state == FILL);
  assign in_acc   = in_valid && in_ready;
  assign insert   = in_acc && (count != CNT_W'(CAPACITY));
  assign step     = (state == DRAIN) && (!out_valid || out_ready);

  assign ctrl.ins   = insert;
  assign ctrl.shift = step;
  assign ctrl.din   = value;

  // Build the chain; cell 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? 0 : i - 1;
    localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;
    logic left_gt;
    assign left_gt = (i == 0) ? 1'b0 : cell_gt[LEFT];

    eis_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CNT_W'(i) < count),
      .left_gt   (left_gt),
      .left_val  (cell_val[LEFT]),
      .right_val (cell_val[RIGHT]),
      .gt        (cell_gt[i]),
      .val       (cell_val[i])
    );
  end

  // Sequence fill and drain, and hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FILL;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !step) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        FILL: begin
          if (in_acc) begin
            if (insert) begin
              count <= count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (end_of_block) begin
              state <= DRAIN;
            end
          end
        end
        DRAIN: begin
          if (step) begin
            out_valid    <= 1'b1;
            sorted_value <= cell_val[0];
            end_of_run   <= (count == CNT_W'(1));
            overflow     <= dropped;
            count        <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state   <= FILL;
              dropped <= 1'b0;
            end
          end
        end
        default: state <= FILL;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("held count beyond capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == DRAIN |-> count != '0)
    else $error("drain with no held values");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    insert |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not advance count");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    step && count == CNT_W'(1) |=> state == FILL && end_of_run && out_valid && !dropped)
    else $error("last drain step did not close the block");

endmodule

// File: design/eis_cell.sv
`timescale 1ns / 1ps
module eis_cell (
  input  logic                             clk,
  input  eis_pkg::cell_ctrl_t              ctrl,
  input  logic                             occupied,
  input  logic                             left_gt,
  input  logic signed [eis_pkg::DATA_W-1:0] left_val,
  input  logic signed [eis_pkg::DATA_W-1:0] right_val,
  output logic                             gt,
  output logic signed [eis_pkg::DATA_W-1:0] val
);
  import eis_pkg::*;

  // An empty cell acts as +infinity; equal values stay put to keep the sort stable
  assign gt = !occupied || (val > ctrl.din);

  // Insert: make room by taking the left value, or take the new value at the boundary.
  // Drain: take the right neighbor's value.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (gt) begin
        val <= left_gt ? left_val : ctrl.din;
      end
    end else if (ctrl.shift) begin
      val <= right_val;
    end
  end

endmodule

// File: dv/sort_checker.sv
`timescale 1ns / 1ps
module sort_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [eis_pkg::DATA_W-1:0] value,
  input  logic                              end_of_block,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [eis_pkg::DATA_W-1:0] sorted_value,
  input  logic                              end_of_run,
  input  logic                              overflow,
  output int                                errors,
  output int                                pending
);
  import eis_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] val;
    logic                     last;
    logic                     ovf;
  } sorted_item_t;

  // Predicted contents of the sorting chain
  logic signed [DATA_W-1:0] held_vals [CAPACITY];
  int                       held_n = 0;
  logic                     drop_seen = 1'b0;
  // Sorted items still owed by the block, oldest first
  sorted_item_t             sorted_due [$];
  int                       mismatch_n = 0;

  // Insert one value behind its equals; on block close, queue the whole sorted run
  task automatic take_value(input logic signed [DATA_W-1:0] v, input logic closes);
    int           pos;
    sorted_item_t r;
    if (held_n < CAPACITY) begin
      pos = held_n;
      while (pos > 0 && held_vals[pos-1] > v) begin
        held_vals[pos] = held_vals[pos-1];
        pos--;
      end
      held_vals[pos] = v;
      held_n++;
    end else begin
      drop_seen = 1'b1;
    end
    if (closes) begin
      for (int k = 0; k < held_n; k++) begin
        r.val  = held_vals[k];
        r.last = (k == held_n - 1);
        r.ovf  = drop_seen;
        sorted_due.push_back(r);
      end
      held_n    = 0;
      drop_seen = 1'b0;
    end
  endtask

  // Compare one output item against the oldest expectation
  task automatic check_result();
    sorted_item_t r;
    if (sorted_due.size() == 0) begin
      mismatch_n++;
      if (mismatch_n <= 10)
        $display("%0t: unexpected item value=%0d last=%b ovf=%b", $realtime,
                 sorted_value, end_of_run, overflow);
    end else begin
      r = sorted_due.pop_front();
      if (sorted_value !== r.val || end_of_run !== r.last || overflow !== r.ovf) begin
        mismatch_n++;
        if (mismatch_n <= 10)
          $display("%0t: mismatch exp value=%0d last=%b ovf=%b got value=%0d last=%b ovf=%b",
                   $realtime, r.val, r.last, r.ovf, sorted_value, end_of_run, overflow);
      end
    end
  endtask

  // Sample both channels at the edge
  always @(posedge clk) begin
    if (rst) begin
      held_n    = 0;
      drop_seen = 1'b0;
      sorted_due.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) take_value(value, end_of_block);
    end
    errors  <= mismatch_n;
    pending <= sorted_due.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import eis_pkg::*;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int ITEM_TARGET = 210;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] value = '0;
  logic                     end_of_block = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     end_of_run;
  logic                     overflow;

  int   errors;
  int   pending;
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   items_sent = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  logic [15:0] ready_pat = 16'hffff;
  int   pat_age = 0;

  always #2 clk = ~clk;

  exchange_insertion_sorter DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .end_of_block (end_of_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .end_of_run   (end_of_run),
    .overflow     (overflow)
  );

  sort_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .end_of_block (end_of_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .end_of_run   (end_of_run),
    .overflow     (overflow),
    .errors       (errors),
    .pending      (pending)
  );

  // Draw a value: mostly full range, some clustered near zero, some at the extremes
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $signed($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one item, inserting a gap between bursts, and hold it until taken
  task automatic put_item(input logic signed [DATA_W-1:0] v, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid     <= 1'b1;
    value        <= v;
    end_of_block <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_block(input int len);
    for (int i = 0; i < len; i++) put_item(pick_value(), i == len - 1);
  endtask

  // Receiver: one long hold-off once the random part starts, else a rotating pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (pat_age == 0) begin
      ready_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      pat_age   <= 63;
      out_ready <= 1'b1;
    end else begin
      out_ready <= ready_pat[0];
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
      pat_age   <= pat_age - 1;
    end
  end

  // Count cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int blk;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-item blocks at the extremes and at zero
    put_item(VAL_MIN, 1'b1);
    put_item(VAL_MAX, 1'b1);
    put_item('0, 1'b1);
    // Mixed extremes with duplicates
    put_item(VAL_MAX, 1'b0);
    put_item(VAL_MIN, 1'b0);
    put_item(-1, 1'b0);
    put_item('0, 1'b0);
    put_item(1, 1'b0);
    put_item(VAL_MIN, 1'b0);
    put_item(VAL_MAX, 1'b0);
    put_item(32'sh4000_0000, 1'b0);
    put_item(-5, 1'b1);
    // Strictly descending run
    put_item(3, 1'b0);
    put_item(2, 1'b0);
    put_item(1, 1'b0);
    put_item('0, 1'b0);
    put_item(-1, 1'b1);
    // Equal pair
    put_item(7, 1'b0);
    put_item(7, 1'b1);

    // Random blocks; one fills the store exactly, one drops past capacity
    hold_go <= 1'b1;
    blk = 0;
    while (items_sent < ITEM_TARGET) begin
      if (blk == 2) send_block(CAPACITY);
      else if (blk == 5) send_block(CAPACITY + 2);
      else send_block($urandom_range(1, 10));
      blk++;
    end
    in_valid <= 1'b0;

    // Wait for the checker to drain, then watch for stray items before the verdict
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
design/eis_pkg.sv
design/eis_cell.sv
design/exchange_insertion_sorter.sv
dv/sort_checker.sv
dv/tb.sv
